FILE: src/slfp_pkg.sv
// Shared types and constants of the sync/length frame parser.
package slfp_pkg;

    // Number of receive channels with their own parser.
    localparam int CHANNELS = 4;
    // Bits needed to index the per-channel state.
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Configuration register indexes and reset values.
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_SYNC    = 1'b1;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [7:0]  SYNC_RESET    = 8'h55;

    // Input item modes.
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Per-channel parse states.
    typedef enum logic [2:0] {
        ST_HUNT = 3'd0,
        ST_CMD  = 3'd1,
        ST_ID   = 3'd2,
        ST_LEN  = 3'd3,
        ST_DATA = 3'd4,
        ST_CRC1 = 3'd5,
        ST_CRC2 = 3'd6
    } parse_state_t;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_FRAME   = 2'd1,
        KIND_TIMEOUT = 2'd2
    } kind_t;

    // One input item.
    typedef struct packed {
        logic       mode;
        logic [1:0] channel;
        logic [7:0] data_byte;
    } item_t;

    // One result item.
    typedef struct packed {
        kind_t       kind;
        logic [1:0]  out_channel;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [7:0]  command_code;
        logic [7:0]  frame_id;
        logic [7:0]  length;
        logic [15:0] frame_crc;
        logic        last_payload;
    } result_t;

endpackage

FILE: src/slfp_in_if.sv
// Valid/ready channel that carries input items into the parser.
interface slfp_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [1:0] channel;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output channel, output data_byte,
                    input ready);
    modport sink (input valid, input mode, input channel, input data_byte,
                  output ready);
endinterface

FILE: src/slfp_out_if.sv
// Valid/ready channel that carries result items out of the parser.
interface slfp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  out_channel;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  command_code;
    logic [7:0]  frame_id;
    logic [7:0]  length;
    logic [15:0] frame_crc;
    logic        last_payload;

    modport source (output valid, output kind, output out_channel, output payload_byte,
                    output payload_index, output command_code, output frame_id,
                    output length, output frame_crc, output last_payload,
                    input ready);
    modport sink (input valid, input kind, input out_channel, input payload_byte,
                  input payload_index, input command_code, input frame_id,
                  input length, input frame_crc, input last_payload,
                  output ready);
endinterface

FILE: src/sync_length_frame_parser.sv
// Per-channel sync/length frame parser with payload, frame and timeout results.
//
//   Channel   Dir  Handshake      Contents
//   items     in   valid/ready    mode, channel, data_byte
//   results   out  valid/ready    kind, out_channel, header, payload, crc
//   wr_*      in   wr_en only     timeout_ticks (index 0), sync_value (index 1)
//
// Every request passes through the input register and then the result register, and
// one request is accepted per cycle while the result register is not stalled.
// The per-channel state is read and written in the single stage between them.
// Reset clears all channels to hunting and loads the register reset values.
// A stalled result holds the input register; items keeps accepting while the
// input register is empty or moving on.
module sync_length_frame_parser (
    input  logic         clk,
    input  logic         rst_n,
    slfp_in_if.sink      items,
    slfp_out_if.source   results,
    input  logic         wr_en,
    input  logic         wr_index,
    input  logic [15:0]  wr_data
);

    // Configuration registers.
    logic [15:0] timeout_reg;
    logic [7:0]  sync_reg;

    // Input register.
    logic                  s1_valid_reg;
    slfp_pkg::item_t       s1_item_reg;

    // Result register.
    logic                  res_valid_reg;
    slfp_pkg::result_t     res_reg;

    // Per-channel state.
    slfp_pkg::parse_state_t parse_state_reg [slfp_pkg::CHANNELS];
    logic [7:0]             cmd_reg         [slfp_pkg::CHANNELS];
    logic [7:0]             id_reg          [slfp_pkg::CHANNELS];
    logic [7:0]             len_reg         [slfp_pkg::CHANNELS];
    logic [7:0]             count_reg       [slfp_pkg::CHANNELS];
    logic [15:0]            crc_reg         [slfp_pkg::CHANNELS];
    logic [15:0]            elapsed_reg     [slfp_pkg::CHANNELS];

    // Next values for the selected channel.
    slfp_pkg::parse_state_t st_next;
    logic [7:0]             cmd_next;
    logic [7:0]             id_next;
    logic [7:0]             len_next;
    logic [7:0]             count_next;
    logic [15:0]            crc_next;
    logic [15:0]            elapsed_next;
    logic                   res_gen;
    slfp_pkg::result_t      res_next;

    logic                              s1_go;
    logic                              ch_ok;
    logic [slfp_pkg::CH_IDX_W-1:0]     ch_idx;
    slfp_pkg::parse_state_t            st_cur;
    logic [7:0]                        count_inc;
    logic                              last;

    // Pipeline control: the input register moves when the result slot frees.
    assign s1_go       = s1_valid_reg && (!res_valid_reg || results.ready);
    assign items.ready = !s1_valid_reg || s1_go;

    assign ch_idx = slfp_pkg::CH_IDX_W'(s1_item_reg.channel);
    assign ch_ok  = (int'(s1_item_reg.channel) < slfp_pkg::CHANNELS);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= slfp_pkg::TIMEOUT_RESET;
            sync_reg    <= slfp_pkg::SYNC_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                slfp_pkg::REG_TIMEOUT: timeout_reg <= wr_data;
                slfp_pkg::REG_SYNC:    sync_reg    <= wr_data[7:0];
                default:               ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (items.ready)
        begin
            s1_valid_reg <= items.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (items.ready && items.valid)
        begin
            s1_item_reg.mode      <= items.mode;
            s1_item_reg.channel   <= items.channel;
            s1_item_reg.data_byte <= items.data_byte;
        end
    end

    // Parse step for the channel of the registered request.
    always_comb
    begin
        st_cur       = parse_state_reg[ch_idx];
        st_next      = st_cur;
        cmd_next     = cmd_reg[ch_idx];
        id_next      = id_reg[ch_idx];
        len_next     = len_reg[ch_idx];
        count_next   = count_reg[ch_idx];
        crc_next     = crc_reg[ch_idx];
        elapsed_next = elapsed_reg[ch_idx];
        count_inc    = count_reg[ch_idx] + 8'd1;
        last         = (count_inc == len_reg[ch_idx]);
        res_gen      = 1'b0;
        res_next     = '0;
        res_next.out_channel = s1_item_reg.channel;

        if (s1_item_reg.mode == slfp_pkg::MODE_TICK)
        begin
            // Ticks only matter while a frame is in progress.
            if (st_cur != slfp_pkg::ST_HUNT)
            begin
                if (elapsed_reg[ch_idx] != 16'hFFFF)
                begin
                    elapsed_next = elapsed_reg[ch_idx] + 16'd1;
                end
                if (elapsed_next > timeout_reg)
                begin
                    st_next       = slfp_pkg::ST_HUNT;
                    res_gen       = 1'b1;
                    res_next.kind = slfp_pkg::KIND_TIMEOUT;
                end
            end
        end
        else
        begin
            unique case (st_cur)
                slfp_pkg::ST_CMD:
                begin
                    cmd_next = s1_item_reg.data_byte;
                    st_next  = slfp_pkg::ST_ID;
                end
                slfp_pkg::ST_ID:
                begin
                    id_next = s1_item_reg.data_byte;
                    st_next = slfp_pkg::ST_LEN;
                end
                slfp_pkg::ST_LEN:
                begin
                    len_next = s1_item_reg.data_byte;
                    st_next  = (s1_item_reg.data_byte == 8'd0) ? slfp_pkg::ST_CRC1
                                                               : slfp_pkg::ST_DATA;
                end
                slfp_pkg::ST_DATA:
                begin
                    count_next = count_inc;
                    if (last)
                    begin
                        st_next = slfp_pkg::ST_CRC1;
                    end
                    res_gen                = 1'b1;
                    res_next.kind          = slfp_pkg::KIND_PAYLOAD;
                    res_next.payload_byte  = s1_item_reg.data_byte;
                    res_next.payload_index = count_reg[ch_idx];
                    res_next.command_code  = cmd_reg[ch_idx];
                    res_next.frame_id      = id_reg[ch_idx];
                    res_next.length        = len_reg[ch_idx];
                    res_next.last_payload  = last;
                end
                slfp_pkg::ST_CRC1:
                begin
                    crc_next = {s1_item_reg.data_byte, 8'h00};
                    st_next  = slfp_pkg::ST_CRC2;
                end
                slfp_pkg::ST_CRC2:
                begin
                    crc_next              = {crc_reg[ch_idx][15:8], s1_item_reg.data_byte};
                    st_next               = slfp_pkg::ST_HUNT;
                    res_gen               = 1'b1;
                    res_next.kind         = slfp_pkg::KIND_FRAME;
                    res_next.command_code = cmd_reg[ch_idx];
                    res_next.frame_id     = id_reg[ch_idx];
                    res_next.length       = len_reg[ch_idx];
                    res_next.frame_crc    = crc_next;
                end
                default:
                begin
                    // Hunting: a sync byte opens a fresh frame.
                    if (s1_item_reg.data_byte == sync_reg)
                    begin
                        cmd_next     = 8'd0;
                        id_next      = 8'd0;
                        len_next     = 8'd0;
                        count_next   = 8'd0;
                        crc_next     = 16'd0;
                        elapsed_next = 16'd0;
                        st_next      = slfp_pkg::ST_CMD;
                    end
                end
            endcase
        end

        // Channels beyond the configured count are dropped.
        if (!ch_ok)
        begin
            res_gen = 1'b0;
        end
    end

    // Per-channel state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < slfp_pkg::CHANNELS; c++)
            begin
                parse_state_reg[c] <= slfp_pkg::ST_HUNT;
                cmd_reg[c]         <= 8'd0;
                id_reg[c]          <= 8'd0;
                len_reg[c]         <= 8'd0;
                count_reg[c]       <= 8'd0;
                crc_reg[c]         <= 16'd0;
                elapsed_reg[c]     <= 16'd0;
            end
        end
        else if (s1_go && ch_ok)
        begin
            parse_state_reg[ch_idx] <= st_next;
            cmd_reg[ch_idx]         <= cmd_next;
            id_reg[ch_idx]          <= id_next;
            len_reg[ch_idx]         <= len_next;
            count_reg[ch_idx]       <= count_next;
            crc_reg[ch_idx]         <= crc_next;
            elapsed_reg[ch_idx]     <= elapsed_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            res_valid_reg <= res_gen;
        end
        else if (results.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && res_gen)
        begin
            res_reg <= res_next;
        end
    end

    assign results.valid         = res_valid_reg;
    assign results.kind          = res_reg.kind;
    assign results.out_channel   = res_reg.out_channel;
    assign results.payload_byte  = res_reg.payload_byte;
    assign results.payload_index = res_reg.payload_index;
    assign results.command_code  = res_reg.command_code;
    assign results.frame_id      = res_reg.frame_id;
    assign results.length        = res_reg.length;
    assign results.frame_crc     = res_reg.frame_crc;
    assign results.last_payload  = res_reg.last_payload;

    // A held input request keeps its contents until the result slot frees.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("input register changed while stalled");

    // Input is refused only behind a pending result that is not taken.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !items.ready |-> s1_valid_reg && res_valid_reg && !results.ready)
        else $error("input refused without a stalled result");

    // A payload index always lies inside the frame length.
    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.kind == slfp_pkg::KIND_PAYLOAD
            |-> results.payload_index < results.length)
        else $error("payload index beyond frame length");

    // A frame or timeout result leaves its channel hunting.
    a_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && res_gen && res_next.kind != slfp_pkg::KIND_PAYLOAD
            |=> parse_state_reg[$past(ch_idx)] == slfp_pkg::ST_HUNT)
        else $error("channel not hunting after frame end");

endmodule

FILE: tb/frame_result_checker.sv
// Checker that predicts the parser's results from accepted requests and compares them.
module frame_result_checker
    import slfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    slfp_in_if          items,
    slfp_out_if         results,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [15:0] wr_data,
    output int          mismatches,
    output int          outstanding,
    output int          payloads_seen,
    output int          frames_seen,
    output int          timeouts_seen
);

    // Our own copy of the per-channel parser state and the registers.
    parse_state_t chan_state [CHANNELS];
    logic [7:0]   cmd_q      [CHANNELS];
    logic [7:0]   id_q       [CHANNELS];
    logic [7:0]   len_q      [CHANNELS];
    logic [7:0]   count_q    [CHANNELS];
    logic [15:0]  crc_q      [CHANNELS];
    logic [15:0]  elapsed_q  [CHANNELS];
    logic [15:0]  timeout_cfg;
    logic [7:0]   sync_cfg;

    // Results the parser still owes us, oldest first.
    result_t      expected_results [$];

    // Advance one channel's parser by one request; returns 1 when a result is due.
    function automatic bit parse_item(input item_t req, output result_t res);
        int         ch;
        logic [7:0] next_count;
        logic       is_last;
        res = '0;
        res.out_channel = req.channel;
        if (req.channel >= CHANNELS)
            return 1'b0;
        ch = req.channel;

        // Ticks only count while a frame is open; the timeout fires past the limit.
        if (req.mode == MODE_TICK)
        begin
            if (chan_state[ch] == ST_HUNT)
                return 1'b0;
            if (elapsed_q[ch] != 16'hFFFF)
                elapsed_q[ch] = elapsed_q[ch] + 16'd1;
            if (elapsed_q[ch] <= timeout_cfg)
                return 1'b0;
            chan_state[ch] = ST_HUNT;
            res.kind = KIND_TIMEOUT;
            return 1'b1;
        end

        case (chan_state[ch])
            ST_HUNT:
            begin
                if (req.data_byte == sync_cfg)
                begin
                    cmd_q[ch]      = 8'd0;
                    id_q[ch]       = 8'd0;
                    len_q[ch]      = 8'd0;
                    count_q[ch]    = 8'd0;
                    crc_q[ch]      = 16'd0;
                    elapsed_q[ch]  = 16'd0;
                    chan_state[ch] = ST_CMD;
                end
                return 1'b0;
            end
            ST_CMD:
            begin
                cmd_q[ch]      = req.data_byte;
                chan_state[ch] = ST_ID;
                return 1'b0;
            end
            ST_ID:
            begin
                id_q[ch]       = req.data_byte;
                chan_state[ch] = ST_LEN;
                return 1'b0;
            end
            ST_LEN:
            begin
                len_q[ch]      = req.data_byte;
                chan_state[ch] = (req.data_byte == 8'd0) ? ST_CRC1 : ST_DATA;
                return 1'b0;
            end
            ST_DATA:
            begin
                next_count = count_q[ch] + 8'd1;
                is_last    = (next_count == len_q[ch]);
                res.kind          = KIND_PAYLOAD;
                res.payload_byte  = req.data_byte;
                res.payload_index = count_q[ch];
                res.command_code  = cmd_q[ch];
                res.frame_id      = id_q[ch];
                res.length        = len_q[ch];
                res.last_payload  = is_last;
                count_q[ch] = next_count;
                if (is_last)
                    chan_state[ch] = ST_CRC1;
                return 1'b1;
            end
            ST_CRC1:
            begin
                crc_q[ch]      = {req.data_byte, 8'h00};
                chan_state[ch] = ST_CRC2;
                return 1'b0;
            end
            ST_CRC2:
            begin
                crc_q[ch]        = {crc_q[ch][15:8], req.data_byte};
                chan_state[ch]   = ST_HUNT;
                res.kind         = KIND_FRAME;
                res.command_code = cmd_q[ch];
                res.frame_id     = id_q[ch];
                res.length       = len_q[ch];
                res.frame_crc    = crc_q[ch];
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic check_field(input string field, input logic [15:0] want_val,
                               input logic [15:0] got_val);
        if (want_val !== got_val)
        begin
            $display("%0t  %s mismatch: expected %0h, got %0h", $time, field, want_val, got_val);
            mismatches++;
        end
    endtask

    // Compare each accepted result, track register writes, predict each accepted request.
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        result_t fresh;
        item_t   req;
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                chan_state[c] = ST_HUNT;
                cmd_q[c]      = 8'd0;
                id_q[c]       = 8'd0;
                len_q[c]      = 8'd0;
                count_q[c]    = 8'd0;
                crc_q[c]      = 16'd0;
                elapsed_q[c]  = 16'd0;
            end
            timeout_cfg = TIMEOUT_RESET;
            sync_cfg    = SYNC_RESET;
            expected_results.delete();
            mismatches    = 0;
            payloads_seen = 0;
            frames_seen   = 0;
            timeouts_seen = 0;
            outstanding  <= 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t  unexpected result: expected none, got kind %0d channel %0d",
                             $time, results.kind, results.out_channel);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("kind", want.kind, results.kind);
                    check_field("out_channel", want.out_channel, results.out_channel);
                    check_field("payload_byte", want.payload_byte, results.payload_byte);
                    check_field("payload_index", want.payload_index, results.payload_index);
                    check_field("command_code", want.command_code, results.command_code);
                    check_field("frame_id", want.frame_id, results.frame_id);
                    check_field("length", want.length, results.length);
                    check_field("frame_crc", want.frame_crc, results.frame_crc);
                    check_field("last_payload", want.last_payload, results.last_payload);
                    case (want.kind)
                        KIND_PAYLOAD: payloads_seen++;
                        KIND_FRAME:   frames_seen++;
                        default:      timeouts_seen++;
                    endcase
                end
            end

            if (wr_en)
            begin
                if (wr_index == REG_TIMEOUT)
                    timeout_cfg = wr_data;
                else
                    sync_cfg = wr_data[7:0];
            end

            if (items.valid && items.ready)
            begin
                req.mode      = items.mode;
                req.channel   = items.channel;
                req.data_byte = items.data_byte;
                if (parse_item(req, fresh))
                    expected_results.push_back(fresh);
            end

            outstanding <= expected_results.size();
        end
    end

endmodule

FILE: tb/testbench.sv
// Top of the frame parser testbench: clock, reset, request and result traffic, verdict.
module testbench;
    import slfp_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int LONG_TICKS    = 32;
    localparam int RANDOM_ITEMS  = 500;
    localparam int LIMIT_CYCLES  = 1_000_000;

    logic        clk;
    logic        rst_n;
    logic        wr_en;
    logic        wr_index;
    logic [15:0] wr_data;

    slfp_in_if  items_ch ();
    slfp_out_if results_ch ();

    int mismatches;
    int outstanding;
    int payloads_seen;
    int frames_seen;
    int timeouts_seen;

    // Traffic shaping shared by the sender and the receiver.
    int         send_gap_max;
    int         accept_stall_max;
    bit         hold_results;
    int         items_sent;
    logic [7:0] cur_sync;
    logic [7:0] byte_plan [CHANNELS][$];

    sync_length_frame_parser i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items_ch),
        .results  (results_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    frame_result_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .items         (items_ch),
        .results       (results_ch),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .payloads_seen (payloads_seen),
        .frames_seen   (frames_seen),
        .timeouts_seen (timeouts_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the parser hangs.
    initial
    begin
        #(LIMIT_CYCLES * 10);
        $display("end of test: mismatches");
        $finish;
    end

    // Offer one request after a random gap and hold it until the parser takes it.
    task automatic send_item(input logic mode, input logic [1:0] chan, input logic [7:0] value);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            items_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items_ch.valid     <= 1'b1;
        items_ch.mode      <= mode;
        items_ch.channel   <= chan;
        items_ch.data_byte <= value;
        @(posedge clk);
        while (!items_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_frame(input logic [1:0] chan, input logic [7:0] cmd, input logic [7:0] id,
                              input logic [7:0] len, input logic [15:0] crc);
        send_item(MODE_BYTE, chan, cur_sync);
        send_item(MODE_BYTE, chan, cmd);
        send_item(MODE_BYTE, chan, id);
        send_item(MODE_BYTE, chan, len);
        for (int i = 0; i < len; i++)
            send_item(MODE_BYTE, chan, 8'($urandom));
        send_item(MODE_BYTE, chan, crc[15:8]);
        send_item(MODE_BYTE, chan, crc[7:0]);
    endtask

    // Stop offering, wait for every owed result, then let in-flight requests drain.
    task automatic wait_idle();
        items_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Registers are only written once the parser has gone quiet.
    task automatic load_settings(input logic [15:0] timeout_val, input logic [7:0] sync_val);
        wait_idle();
        wr_en    <= 1'b1;
        wr_index <= REG_TIMEOUT;
        wr_data  <= timeout_val;
        @(posedge clk);
        wr_index <= REG_SYNC;
        wr_data  <= {8'h00, sync_val};
        @(posedge clk);
        wr_en    <= 1'b0;
        cur_sync = sync_val;
    endtask

    // Queue up the next bytes for one channel: mostly whole frames, some noise or cut frames.
    task automatic plan_bytes(input int chan);
        int         roll;
        int         len;
        int         cut;
        logic [7:0] frame [$];
        roll = $urandom_range(0, 99);
        if (roll < 10)
        begin
            repeat ($urandom_range(1, 4)) byte_plan[chan].push_back(8'($urandom));
            return;
        end
        if (roll == 99)
            len = 255;
        else if (roll < 16)
            len = 0;
        else
            len = $urandom_range(1, 12);
        frame.push_back(cur_sync);
        frame.push_back(8'($urandom));
        frame.push_back(8'($urandom));
        frame.push_back(8'(len));
        repeat (len) frame.push_back(8'($urandom));
        frame.push_back(8'($urandom));
        frame.push_back(8'($urandom));
        if (roll < 24)
        begin
            cut = $urandom_range(1, frame.size() - 1);
            while (frame.size() > cut)
                void'(frame.pop_back());
        end
        foreach (frame[i])
            byte_plan[chan].push_back(frame[i]);
    endtask

    // Result receiver: random stalls per result, plus one long hold on request.
    initial
    begin : receiver
        int stall;
        results_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_results)
            begin
                hold_results = 1'b0;
                results_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = $urandom_range(0, accept_stall_max);
            if (stall > 0)
            begin
                results_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            results_ch.ready <= 1'b1;
            @(posedge clk);
            while (!results_ch.valid)
                @(posedge clk);
        end
    end

    // Stimulus and verdict.
    initial
    begin : stimulus
        int         ch;
        int         guard;
        logic [15:0] timeout_val;
        logic [7:0]  sync_val;

        items_ch.valid     <= 1'b0;
        items_ch.mode      <= MODE_BYTE;
        items_ch.channel   <= 2'd0;
        items_ch.data_byte <= 8'h00;
        wr_en              <= 1'b0;
        wr_index           <= REG_TIMEOUT;
        wr_data            <= 16'h0000;
        rst_n              <= 1'b0;
        send_gap_max       = 0;
        accept_stall_max   = 0;
        hold_results       = 1'b0;
        items_sent         = 0;
        cur_sync           = SYNC_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: header extremes, sync value as payload, zero length, idle ticks.
        send_item(MODE_TICK, 2'd0, 8'hFF);
        send_item(MODE_BYTE, 2'd1, SYNC_RESET);
        send_item(MODE_BYTE, 2'd1, 8'hFF);
        send_item(MODE_BYTE, 2'd1, 8'h00);
        send_item(MODE_BYTE, 2'd1, 8'd2);
        send_item(MODE_BYTE, 2'd1, SYNC_RESET);
        send_item(MODE_BYTE, 2'd1, 8'hFF);
        send_item(MODE_BYTE, 2'd1, 8'hFF);
        send_item(MODE_BYTE, 2'd1, 8'h00);
        send_frame(2'd2, 8'h00, 8'hFF, 8'd0, 16'h00FF);
        send_item(MODE_BYTE, 2'd3, SYNC_RESET);
        send_item(MODE_BYTE, 2'd3, 8'h5A);
        send_item(MODE_BYTE, 2'd3, 8'hA5);
        send_item(MODE_TICK, 2'd3, 8'h00);

        // Zero timeout: the next tick on an open frame expires it, bytes never do.
        load_settings(16'd0, 8'h00);
        send_item(MODE_TICK, 2'd3, 8'h00);
        send_item(MODE_BYTE, 2'd0, 8'h00);
        send_item(MODE_BYTE, 2'd0, 8'h00);
        send_item(MODE_BYTE, 2'd0, 8'h00);
        send_item(MODE_TICK, 2'd0, 8'h00);

        // Largest timeout: an open frame outlives a run of ticks, and the counter
        // it built up trips a timeout as soon as the limit drops below it.
        load_settings(16'hFFFF, SYNC_RESET);
        send_item(MODE_BYTE, 2'd2, SYNC_RESET);
        send_item(MODE_BYTE, 2'd2, 8'h11);
        send_item(MODE_BYTE, 2'd2, 8'h22);
        for (int i = 0; i < LONG_TICKS; i++)
            send_item(MODE_TICK, 2'd2, 8'($urandom));
        load_settings(16'd20, SYNC_RESET);
        send_item(MODE_TICK, 2'd2, 8'h00);

        // Back-pressure: the receiver holds off while a long frame keeps coming.
        wait_idle();
        accept_stall_max = 2;
        hold_results = 1'b1;
        send_frame(2'd0, 8'h3C, 8'hC3, 8'd40, 16'h1234);

        // Random: interleaved frames, noise and cut frames under four register settings.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin timeout_val = 16'd3;     sync_val = SYNC_RESET; end
                1:       begin timeout_val = 16'd1;     sync_val = 8'h00;      end
                2:       begin timeout_val = 16'hFFFF;  sync_val = 8'hFF;      end
                default:
                begin
                    timeout_val = 16'($urandom_range(2, 20));
                    sync_val    = 8'($urandom);
                end
            endcase
            load_settings(timeout_val, sync_val);
            for (int n = 0; n < RANDOM_ITEMS; n++)
            begin
                if (n % 64 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       send_gap_max = 0;
                        1:       send_gap_max = 4;
                        default: send_gap_max = 16;
                    endcase
                    case ($urandom_range(0, 2))
                        0:       accept_stall_max = 0;
                        1:       accept_stall_max = 4;
                        default: accept_stall_max = 16;
                    endcase
                end
                ch = $urandom_range(0, CHANNELS - 1);
                if ($urandom_range(0, 99) < 15)
                    send_item(MODE_TICK, 2'(ch), 8'($urandom));
                else
                begin
                    if (byte_plan[ch].size() == 0)
                        plan_bytes(ch);
                    send_item(MODE_BYTE, 2'(ch), byte_plan[ch].pop_front());
                end
            end
        end

        // Drain: wait for owed results with a bound, then watch for strays.
        items_ch.valid <= 1'b0;
        @(posedge clk);
        guard = 0;
        while (outstanding != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES * 4) @(posedge clk);

        $display("Run covered %0d requests: directed header, timeout and back-pressure cases",
                 items_sent);
        $display("plus random traffic; checked %0d payload bytes, %0d frames, %0d timeouts.",
                 payloads_seen, frames_seen, timeouts_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
